[design/plre_pkg.sv]
package plre_pkg;

	localparam int SEQ_W      = 32;
	localparam int CNT_W      = 32;
	localparam int PROB_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;

	// interval numerator is 2^FRAC_W + p/2, one bit wider than a fraction
	localparam int DIV_Q_W    = FRAC_W + 1;
	localparam int DIV_STEP_W = $clog2(DIV_Q_W + 1);

	localparam logic [CNT_W-1:0]      CNT_MAX     = '1;
	localparam logic [PROB_W-1:0]     PROB_MAX    = '1;
	localparam logic [DIV_Q_W-1:0]    ONE_Q       = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [DIV_STEP_W-1:0] RATIO_STEPS = DIV_STEP_W'(FRAC_W);
	localparam logic [DIV_STEP_W-1:0] IVL_STEPS   = DIV_STEP_W'(DIV_Q_W);

	localparam logic [CFG_W-1:0] INITIAL_LOSS_RST = 16'd655;
	localparam logic [CFG_W-1:0] MAX_LOSS_RST     = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_LOSS = 1'b0,
		REG_MAX_LOSS     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic first;
		logic classify;
		logic accum;
		logic ratio_setup;
		logic take_ratio;
		logic ivl_setup;
		logic take_ivl;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_first;
		logic init_nz;
		logic newer;
		logic gap;
		logic run_hit;
		logic ratio_sat;
		logic prob_zero;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

[design/plre_div.sv]
module plre_div
	import plre_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [CNT_W-1:0]      rem_init,
	input  logic [DIV_Q_W-1:0]    num_bits,
	input  logic [CNT_W-1:0]      den,
	input  logic [DIV_STEP_W-1:0] steps,
	output logic                  done,
	output logic [DIV_Q_W-1:0]    quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      den_q;
	logic [DIV_Q_W-1:0]    feed_q;
	logic [DIV_Q_W-1:0]    quot_q;
	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        diff;
	logic                  fits;

	// restoring division, one quotient bit per cycle; remainder stays below den
	assign trial = {rem_q, feed_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= rem_init;
			den_q  <= den;
			feed_q <= num_bits;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			feed_q <= {feed_q[DIV_Q_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[design/plre_ctrl.sv]
module plre_ctrl
	import plre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_FIRST     = 11'b000_0000_0010,
		ST_INIT_DIV  = 11'b000_0000_0100,
		ST_CLASS     = 11'b000_0000_1000,
		ST_ACCUM     = 11'b000_0001_0000,
		ST_CHECK     = 11'b000_0010_0000,
		ST_RATIO     = 11'b000_0100_0000,
		ST_RATIO_DIV = 11'b000_1000_0000,
		ST_IVL       = 11'b001_0000_0000,
		ST_IVL_DIV   = 11'b010_0000_0000,
		ST_OUT       = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (status.need_first) begin
					cmd.first = 1'b1;
					state_d   = status.init_nz ? ST_INIT_DIV : ST_CLASS;
				end else begin
					state_d = ST_CLASS;
				end
			end
			ST_INIT_DIV: begin
				if (status.div_done) begin
					cmd.take_ivl = 1'b1;
					state_d      = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				state_d      = status.newer ? ST_ACCUM : ST_OUT;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = status.gap ? ST_RATIO : ST_CHECK;
			end
			ST_CHECK: begin
				state_d = status.run_hit ? ST_RATIO : ST_OUT;
			end
			ST_RATIO: begin
				cmd.ratio_setup = 1'b1;
				if (status.ratio_sat) begin
					state_d = status.gap ? ST_IVL : ST_OUT;
				end else begin
					state_d = ST_RATIO_DIV;
				end
			end
			ST_RATIO_DIV: begin
				if (status.div_done) begin
					cmd.take_ratio = 1'b1;
					state_d        = status.gap ? ST_IVL : ST_OUT;
				end
			end
			ST_IVL: begin
				cmd.ivl_setup = 1'b1;
				state_d       = status.prob_zero ? ST_OUT : ST_IVL_DIV;
			end
			ST_IVL_DIV: begin
				if (status.div_done) begin
					cmd.take_ivl = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/plre_dp.sv]
module plre_dp
	import plre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [SEQ_W-1:0]     seq,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PROB_W-1:0]    loss_prob,
	output logic                 loss_event,
	output logic                 out_of_order
);

	logic [CFG_W-1:0]  init_loss_q;
	logic [CFG_W-1:0]  max_loss_q;

	logic [SEQ_W-1:0]  seq_q;
	logic [SEQ_W-1:0]  last_seq_q;
	logic [SEQ_W-1:0]  d_q;
	logic              started_q;
	logic              gap_q;
	logic              ooo_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  lost_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  ivl_q;
	logic [PROB_W-1:0] prob_q;

	logic              out_valid_q;
	logic [PROB_W-1:0] out_prob_q;
	logic              out_gap_q;
	logic              out_ooo_q;

	logic [SEQ_W-1:0]  d_c;
	logic              older_c;
	logic              newer_c;
	logic [CNT_W:0]    sum_td;
	logic              halve_c;
	logic [CNT_W:0]    lost_add;
	logic [CNT_W:0]    total_add;
	logic [CNT_W:0]    run_add;
	logic [CNT_W-1:0]  lost_next;
	logic [CNT_W-1:0]  total_next;
	logic [CNT_W-1:0]  run_next;
	logic [CNT_W-1:0]  lost_p1;
	logic [CNT_W-1:0]  total_p1;
	logic [CNT_W-1:0]  num_c;
	logic [CNT_W-1:0]  den_c;
	logic              ratio_sat;
	logic              prob_zero;
	logic              init_nz;

	logic [PROB_W-1:0]     ivl_src;
	logic                  div_go;
	logic [CNT_W-1:0]      div_rem;
	logic [DIV_Q_W-1:0]    div_bits;
	logic [CNT_W-1:0]      div_den;
	logic [DIV_STEP_W-1:0] div_steps;
	logic                  div_done;
	logic [DIV_Q_W-1:0]    div_quot;
	logic [PROB_W-1:0]     quot_p;
	logic [PROB_W-1:0]     quot_clamped;

	// modular distance to the last in-order number; top bit set means older
	assign d_c     = seq_q - last_seq_q;
	assign older_c = d_c[SEQ_W-1];
	assign newer_c = (d_c != '0) && !older_c;
	assign sum_td  = {1'b0, total_q} + {1'b0, d_c};
	assign halve_c = sum_td >= {1'b0, CNT_MAX};

	assign lost_add   = {1'b0, lost_q} + {1'b0, d_q} - {{CNT_W{1'b0}}, 1'b1};
	assign total_add  = {1'b0, total_q} + {1'b0, d_q};
	assign run_add    = {1'b0, run_q} + {{CNT_W{1'b0}}, 1'b1};
	assign lost_next  = lost_add[CNT_W] ? CNT_MAX : lost_add[CNT_W-1:0];
	assign total_next = total_add[CNT_W] ? CNT_MAX : total_add[CNT_W-1:0];
	assign run_next   = run_add[CNT_W] ? CNT_MAX : run_add[CNT_W-1:0];

	assign lost_p1   = (lost_q == CNT_MAX) ? CNT_MAX : lost_q + 1'b1;
	assign total_p1  = (total_q == CNT_MAX) ? CNT_MAX : total_q + 1'b1;
	// total is at least 2 after a gap, so total-1 is never zero
	assign num_c     = gap_q ? lost_q : lost_p1;
	assign den_c     = gap_q ? (total_q - 1'b1) : total_p1;
	assign ratio_sat = num_c >= den_c;
	assign prob_zero = (prob_q == '0);
	assign init_nz   = (init_loss_q != '0);

	assign ivl_src   = cmd.first ? init_loss_q : prob_q;
	assign div_go    = (cmd.first && init_nz) || (cmd.ratio_setup && !ratio_sat)
	                   || (cmd.ivl_setup && !prob_zero);
	assign div_rem   = cmd.ratio_setup ? num_c : '0;
	assign div_bits  = cmd.ratio_setup ? '0
	                   : ONE_Q + DIV_Q_W'({1'b0, ivl_src[PROB_W-1:1]});
	assign div_den   = cmd.ratio_setup ? den_c : CNT_W'(ivl_src);
	assign div_steps = cmd.ratio_setup ? RATIO_STEPS : IVL_STEPS;

	assign quot_p       = div_quot[PROB_W-1:0];
	assign quot_clamped = (quot_p > max_loss_q) ? max_loss_q : quot_p;

	plre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.rem_init (div_rem),
		.num_bits (div_bits),
		.den      (div_den),
		.steps    (div_steps),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_loss_q <= INITIAL_LOSS_RST;
			max_loss_q  <= MAX_LOSS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INITIAL_LOSS: init_loss_q <= cfg_data;
				REG_MAX_LOSS:     max_loss_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			last_seq_q <= '0;
			total_q    <= '0;
			lost_q     <= '0;
			run_q      <= '0;
			ivl_q      <= '0;
			prob_q     <= '0;
		end else begin
			if (cmd.first) begin
				started_q  <= 1'b1;
				prob_q     <= init_loss_q;
				ivl_q      <= '0;
				last_seq_q <= seq_q - 1'b1;
			end
			if (cmd.classify) begin
				if (older_c && (lost_q != '0)) begin
					lost_q <= lost_q - 1'b1;
				end
				if (newer_c) begin
					last_seq_q <= seq_q;
					if (halve_c) begin
						total_q <= total_q >> 1;
						lost_q  <= lost_q >> 1;
					end
				end
			end
			if (cmd.accum) begin
				lost_q  <= lost_next;
				total_q <= total_next;
				run_q   <= gap_q ? CNT_W'(1) : run_next;
			end
			if (cmd.ratio_setup && ratio_sat) begin
				prob_q <= gap_q ? PROB_MAX : max_loss_q;
			end
			if (cmd.take_ratio) begin
				prob_q <= gap_q ? quot_p : quot_clamped;
			end
			if (cmd.ivl_setup && prob_zero) begin
				ivl_q <= '0;
			end
			if (cmd.take_ivl) begin
				ivl_q <= CNT_W'(div_quot);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq;
			gap_q <= 1'b0;
			ooo_q <= 1'b0;
		end
		if (cmd.classify) begin
			ooo_q <= older_c;
			if (newer_c) begin
				d_q   <= d_c;
				gap_q <= (d_c != SEQ_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_prob_q <= prob_q;
			out_gap_q  <= gap_q;
			out_ooo_q  <= ooo_q;
		end
	end

	assign status.need_first = !started_q;
	assign status.init_nz    = init_nz;
	assign status.newer      = newer_c;
	assign status.gap        = gap_q;
	assign status.run_hit    = run_q >= ivl_q;
	assign status.ratio_sat  = ratio_sat;
	assign status.prob_zero  = prob_zero;
	assign status.div_done   = div_done;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign loss_prob    = out_prob_q;
	assign loss_event   = out_gap_q;
	assign out_of_order = out_ooo_q;

endmodule

[design/packet_loss_rate_estimator_core.sv]
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata[31:0] = seq
// m_*       out        m_tvalid/m_tready  m_tdata[15:0] = loss_prob, m_tuser = flags
// cfg_*     in         cfg_wr_en          cfg_index selects register, cfg_data value
//
// one beat in flight; a duplicate or older number needs no division, an in-order one divides
// for the ratio only on a run hit, a gap for the ratio and then the interval (one-bit-per-cycle
// divider); the first beat also divides for its interval unless initial_loss is zero
// arst_n clears all estimator state and loads the register defaults
// s_tready is high only between beats; a waiting result stays in the output register while
// the next beat is taken in, and m_tready low stalls only a second result
module packet_loss_rate_estimator_core
	import plre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SEQ_W-1:0]     s_tdata,   // [31:0] seq
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PROB_W-1:0]    m_tdata,   // [15:0] loss_prob
	output logic [1:0]           m_tuser,   // [0] loss_event, [1] out_of_order
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       loss_event;
	logic       out_of_order;

	plre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	plre_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.seq          (s_tdata),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.loss_prob    (m_tdata),
		.loss_event   (loss_event),
		.out_of_order (out_of_order)
	);

	assign m_tuser = {out_of_order, loss_event};

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a beat is still in work");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("gap and out-of-order flagged on one result");

	a_div_done_taken: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (cmd.take_ivl || cmd.take_ratio))
		else $error("divider result not consumed");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result lost at output register");
`endif

endmodule

[bench/packet_loss_rate_estimator_core_tb.sv]
`timescale 1ns / 1ps

module packet_loss_rate_estimator_core_tb;
	import plre_pkg::*;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic              gap;
		logic              ooo;
	} est_result_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic             typed;
		est_result_t      want;
	} dir_row_t;

	localparam int N_OPEN      = 12;
	localparam int N_TAIL      = 7;
	localparam int N_PHASES    = 5;
	localparam int PHASE_ITEMS = 356;
	localparam int HOLD_AT     = 1500;
	localparam int HOLD_LEN    = 500;
	localparam int SETTLE      = 80;

	bit                   clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [SEQ_W-1:0]     s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PROB_W-1:0]    m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// estimator mirror
	logic [CFG_W-1:0]  est_init_loss;
	logic [CFG_W-1:0]  est_loss_cap;
	logic              est_started;
	logic [SEQ_W-1:0]  est_last;
	logic [CNT_W-1:0]  est_total;
	logic [CNT_W-1:0]  est_lost;
	logic [CNT_W-1:0]  est_run;
	logic [CNT_W-1:0]  est_ivl;
	logic [PROB_W-1:0] est_prob;

	est_result_t      loss_expect_q[$];
	dir_row_t         open_rows [N_OPEN];
	logic [SEQ_W-1:0] tail_steps [N_TAIL];
	int               mismatches;
	int               burst_left;
	int               inorder_left;

	packet_loss_rate_estimator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] sat_cnt(input longint unsigned v);
		return (v > 64'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
	endfunction

	function automatic logic [PROB_W-1:0] q_ratio(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		q = (num << FRAC_W) / den;
		return (q > 64'(PROB_MAX)) ? PROB_MAX : q[PROB_W-1:0];
	endfunction

	// about 1/p, rounded half up
	function automatic logic [CNT_W-1:0] interval_of_prob(input logic [PROB_W-1:0] p);
		longint unsigned num;
		if (p == '0)
			return '0;
		num = (64'd1 << FRAC_W) + 64'(p >> 1);
		return sat_cnt(num / 64'(p));
	endfunction

	function automatic est_result_t estimate_seq(input logic [SEQ_W-1:0] s);
		est_result_t      r;
		logic [SEQ_W-1:0] d;
		r = '0;
		if (!est_started) begin
			est_started = 1'b1;
			est_prob    = est_init_loss;
			est_ivl     = interval_of_prob(est_init_loss);
			est_last    = s - 1'b1;
		end
		d = s - est_last;
		if (d[SEQ_W-1]) begin
			r.ooo = 1'b1;
			if (est_lost != '0)
				est_lost = est_lost - 1'b1;
		end else if (d != '0) begin
			// halve both counters before the total would saturate
			if (64'(est_total) + 64'(d) >= 64'(CNT_MAX)) begin
				est_total = est_total >> 1;
				est_lost  = est_lost >> 1;
			end
			est_lost  = sat_cnt(64'(est_lost) + 64'(d) - 64'd1);
			est_total = sat_cnt(64'(est_total) + 64'(d));
			if (d != 1) begin
				r.gap    = 1'b1;
				est_prob = q_ratio(64'(est_lost), 64'(est_total) - 64'd1);
				est_ivl  = interval_of_prob(est_prob);
				est_run  = CNT_W'(1);
			end else begin
				est_run = sat_cnt(64'(est_run) + 64'd1);
				if (est_run >= est_ivl) begin
					est_prob = q_ratio(64'(sat_cnt(64'(est_lost) + 64'd1)),
						64'(sat_cnt(64'(est_total) + 64'd1)));
					if (est_prob > est_loss_cap)
						est_prob = est_loss_cap;
				end
			end
			est_last = s;
		end
		r.prob = est_prob;
		return r;
	endfunction

	// mostly in-order runs with random length, broken by gaps, repeats and stale numbers
	function automatic logic [SEQ_W-1:0] pick_seq(input logic wild);
		logic [SEQ_W-1:0] s;
		s = est_last + 1'b1;
		if (inorder_left > 0) begin
			inorder_left--;
		end else begin
			inorder_left = $urandom_range(0, 40);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: s = est_last + $urandom_range(2, 4);
				8, 9:                   s = est_last + $urandom_range(5, 40);
				10, 11:                 s = est_last;
				12, 13, 14, 15:         s = est_last - $urandom_range(1, 60);
				16:                     s = wild ? est_last + $urandom_range(1, 32'h7FFF_FFFF)
					: est_last + $urandom_range(2, 4);
				17:                     s = wild ? $urandom : est_last + 1'b1;
				default:                s = est_last + 1'b1;
			endcase
		end
		return s;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_INITIAL_LOSS: est_init_loss = v;
			REG_MAX_LOSS:     est_loss_cap  = v;
			default:          ;
		endcase
	endtask

	// offers one beat and keeps tvalid up while a burst lasts
	task automatic send_seq(input logic [SEQ_W-1:0] s, input logic typed,
			input est_result_t typed_want);
		est_result_t got;
		s_tdata  <= s;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		got = estimate_seq(s);
		loss_expect_q.push_back(typed ? typed_want : got);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (loss_expect_q.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin : result_check
		est_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (loss_expect_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat prob=%0d flags=%b", m_tdata, m_tuser));
			end else begin
				want = loss_expect_q.pop_front();
				if (m_tdata !== want.prob)
					flag_mismatch($sformatf("loss_prob %0d, want %0d", m_tdata, want.prob));
				if (m_tuser[0] !== want.gap)
					flag_mismatch($sformatf("loss_event %b, want %b", m_tuser[0], want.gap));
				if (m_tuser[1] !== want.ooo)
					flag_mismatch($sformatf("out_of_order %b, want %b", m_tuser[1], want.ooo));
			end
		end
	end

	initial begin : sink_pace
		int cyc;
		int mode;
		m_tready = 1'b0;
		cyc      = 0;
		mode     = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT) begin
				// long hold-off: one result parks in the output stage, then the input blocks
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else begin
				if (cyc % 128 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (cyc % 7) >= 3;
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] cap;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_INITIAL_LOSS;
		cfg_data      = '0;
		mismatches    = 0;
		burst_left    = 0;
		inorder_left  = 0;
		est_init_loss = INITIAL_LOSS_RST;
		est_loss_cap  = MAX_LOSS_RST;
		est_started   = 1'b0;
		est_last      = '0;
		est_total     = '0;
		est_lost      = '0;
		est_run       = '0;
		est_ivl       = '0;
		est_prob      = '0;

		// starts near the wrap with initial_loss 1; typed rows follow by hand
		open_rows = '{
			'{32'hFFFF_FFFD, 1'b1, '{16'd1,     1'b0, 1'b0}},  // first beat
			'{32'hFFFF_FFFD, 1'b1, '{16'd1,     1'b0, 1'b0}},  // repeat
			'{32'hFFFF_FFFC, 1'b1, '{16'd1,     1'b0, 1'b1}},  // stale, lost stays 0
			'{32'h0000_0002, 1'b1, '{16'd52428, 1'b1, 1'b0}},  // gap across the wrap
			'{32'h0000_0003, 1'b1, '{16'd32768, 1'b0, 1'b0}},  // run hit, clamped
			'{32'h0000_0000, 1'b1, '{16'd32768, 1'b0, 1'b1}},
			'{32'h0000_0004, 1'b0, '0},
			'{32'h0000_0005, 1'b0, '0},
			'{32'h0000_0007, 1'b0, '0},
			'{32'h0000_0007, 1'b0, '0},
			'{32'h0000_0006, 1'b0, '0},
			'{32'h0000_0008, 1'b0, '0}
		};
		// steps from the newest number: widest newer jump, exact half range, halving
		tail_steps = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0,
			32'h7FFF_FFFF, 32'd1};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_reg(REG_INITIAL_LOSS, 16'd1);
		write_reg(REG_MAX_LOSS, 16'd32768);

		foreach (open_rows[i])
			send_seq(open_rows[i].seq, open_rows[i].typed, open_rows[i].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			case (ph)
				0:       cap = 16'hFFFF;
				1:       cap = 16'h0000;
				3:       cap = 16'd32768;
				default: cap = 16'($urandom);
			endcase
			// initial_loss only counts on the first beat, later writes must not matter
			write_reg(REG_INITIAL_LOSS, (ph % 2 == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
			write_reg(REG_MAX_LOSS, cap);
			repeat (PHASE_ITEMS)
				send_seq(pick_seq(ph == N_PHASES - 1), 1'b0, '0);
		end

		// huge jumps run last so the counters stay small through the random part
		foreach (tail_steps[i])
			send_seq(est_last + tail_steps[i], 1'b0, '0);

		drain_results();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#1_500_000;
		$display("FAIL");
		$finish;
	end

endmodule
